[rtl/efd_pkg.sv]
// shared constants, status codes and the crc-8 byte update for the escaped frame decoder
// no dependencies; imported by escaped_frame_decoder_crc8
`default_nettype none

package efd_pkg;

    localparam int unsigned MAX_RECORD_DEFAULT = 256;

    localparam logic [7:0] HEAD_BYTE = 8'hab;
    localparam logic [7:0] TAIL_BYTE = 8'hcd;
    localparam logic [7:0] ESC_BYTE  = 8'hea;
    localparam int unsigned OVERHEAD = 5;
    localparam logic [7:0] CRC_POLY  = 8'h07;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_LEN_BAD   = 3'd2,
        ST_CRC_BAD   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_ABORTED   = 3'd5
    } frame_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } result_kind_t;

    // crc-8, msb first, one byte per call
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/escaped_frame_decoder_crc8.sv]
// escaped frame decoder with crc-8 check, single module
// depends on efd_pkg for byte codes, status codes and the crc update
`default_nettype none

// usage
//   s_ channel: one raw line byte per transfer (s_rx_byte)
//   m_ channel: zero or one result per input byte, either a payload byte
//     (m_result_kind 0) or an end-of-frame status (m_result_kind 1) with
//     the frame id and the payload count
//   bytes before a head 0xab are dropped; inside a frame 0xea escapes the
//     next byte; id, length and crc bytes follow the head; tail 0xcd closes
//   result timing: a result is on m_ after the clock edge that takes its byte,
//     so m_valid rises in the cycle after the input transfer
//   throughput: one byte per cycle while the result register is not stalled; parse, escape handling and the crc-8
//     byte update all sit in one combinational step between the parser
//     state registers and the result register
//   stall: the result register holds while m_ready is low; s_ready drops
//     only when that register is full and not being drained, so a byte is
//     taken in the same cycle its predecessor's result leaves
//   reset (aresetn low, synchronous): out of frame, no escape pending,
//     counters and header fields cleared, result register empty
module escaped_frame_decoder_crc8
    import efd_pkg::*;
#(
    parameter int unsigned MAX_RECORD = MAX_RECORD_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_result_kind,
    output logic [7:0]      m_payload_byte,
    output logic [2:0]      m_frame_status,
    output logic [7:0]      m_frame_id,
    output logic [7:0]      m_payload_count
);

    // record count never passes MAX_RECORD-1
    localparam int unsigned CNT_W = $clog2(MAX_RECORD);
    // working width for count arithmetic: room for the count plus one and for 255
    localparam int unsigned EXT_W = (CNT_W > 8) ? CNT_W + 1 : 9;
    localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_RECORD);
    localparam logic [EXT_W-1:0] OVH_EXT  = EXT_W'(OVERHEAD);
    localparam logic [EXT_W-1:0] HDR_EXT  = EXT_W'(4);
    localparam logic [EXT_W-1:0] SAT_EXT  = EXT_W'(255);

    // parser state
    logic             in_frame_reg,  in_frame_next;
    logic             esc_reg,       esc_next;
    logic [CNT_W-1:0] rec_cnt_reg,   rec_cnt_next;
    logic [7:0]       hdr_id_reg,    hdr_id_next;
    logic [7:0]       decl_len_reg,  decl_len_next;
    logic [7:0]       rx_crc_reg,    rx_crc_next;
    logic [7:0]       crc_reg,       crc_next;

    // result register
    logic             m_valid_reg,   m_valid_next;
    result_kind_t     kind_reg,      kind_next;
    logic [7:0]       pbyte_reg,     pbyte_next;
    frame_status_t    status_reg,    status_next;
    logic [7:0]       id_reg,        id_next;
    logic [7:0]       pcnt_reg,      pcnt_next;

    logic             take;
    logic             emit;
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] cnt_inc;

    // payload bytes for a given record count, saturating at 255
    function automatic logic [7:0] payload_of(input logic [EXT_W-1:0] cnt);
        logic [EXT_W-1:0] n;
        n = (cnt > HDR_EXT) ? cnt - HDR_EXT : '0;
        return (n > SAT_EXT) ? 8'hff : n[7:0];
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign cnt_ext = EXT_W'(rec_cnt_reg);
    assign cnt_inc = cnt_ext + EXT_W'(1);

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        rec_cnt_next  = rec_cnt_reg;
        hdr_id_next   = hdr_id_reg;
        decl_len_next = decl_len_reg;
        rx_crc_next   = rx_crc_reg;
        crc_next      = crc_reg;

        emit          = 1'b0;
        kind_next     = KIND_STATUS;
        pbyte_next    = 8'h00;
        status_next   = ST_OK;
        id_next       = hdr_id_reg;
        pcnt_next     = payload_of(cnt_ext);

        if (take) begin
            if (!in_frame_reg) begin
                // hunting for a head, everything else dropped
                if (s_rx_byte == HEAD_BYTE) begin
                    in_frame_next = 1'b1;
                    esc_next      = 1'b0;
                    rec_cnt_next  = CNT_W'(1);
                    hdr_id_next   = 8'h00;
                    decl_len_next = 8'h00;
                    rx_crc_next   = 8'h00;
                    crc_next      = 8'h00;
                end
            end else if (!esc_reg && s_rx_byte == ESC_BYTE) begin
                esc_next = 1'b1;
            end else if (!esc_reg && s_rx_byte == HEAD_BYTE) begin
                // old frame aborted, new frame opens right away
                emit          = 1'b1;
                status_next   = ST_ABORTED;
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                rec_cnt_next  = CNT_W'(1);
                hdr_id_next   = 8'h00;
                decl_len_next = 8'h00;
                rx_crc_next   = 8'h00;
                crc_next      = 8'h00;
            end else if (!esc_reg && s_rx_byte == TAIL_BYTE) begin
                // checks in priority order: size, length, crc
                emit = 1'b1;
                if (cnt_inc <= OVH_EXT) begin
                    status_next = ST_SHORT;
                end else if ((cnt_ext - HDR_EXT) != EXT_W'(decl_len_reg)) begin
                    status_next = ST_LEN_BAD;
                end else if (crc_reg != rx_crc_reg) begin
                    status_next = ST_CRC_BAD;
                end else begin
                    status_next = ST_OK;
                end
                in_frame_next = 1'b0;
                esc_next      = 1'b0;
            end else begin
                // data byte, literal or escaped
                esc_next = 1'b0;
                if (cnt_inc >= MAX_EXT) begin
                    emit          = 1'b1;
                    status_next   = ST_OVERFLOW;
                    in_frame_next = 1'b0;
                end else if (cnt_ext == EXT_W'(1)) begin
                    hdr_id_next  = s_rx_byte;
                    crc_next     = s_rx_byte;
                    rec_cnt_next = cnt_inc[CNT_W-1:0];
                end else if (cnt_ext == EXT_W'(2)) begin
                    decl_len_next = s_rx_byte;
                    rec_cnt_next  = cnt_inc[CNT_W-1:0];
                end else if (cnt_ext == EXT_W'(3)) begin
                    rx_crc_next  = s_rx_byte;
                    rec_cnt_next = cnt_inc[CNT_W-1:0];
                end else begin
                    emit         = 1'b1;
                    kind_next    = KIND_PAYLOAD;
                    pbyte_next   = s_rx_byte;
                    pcnt_next    = payload_of(cnt_inc);
                    crc_next     = crc8_byte(crc_reg, s_rx_byte);
                    rec_cnt_next = cnt_inc[CNT_W-1:0];
                end
            end
        end
    end

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            rec_cnt_reg  <= '0;
            hdr_id_reg   <= 8'h00;
            decl_len_reg <= 8'h00;
            rx_crc_reg   <= 8'h00;
            crc_reg      <= 8'h00;
            m_valid_reg  <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            rec_cnt_reg  <= rec_cnt_next;
            hdr_id_reg   <= hdr_id_next;
            decl_len_reg <= decl_len_next;
            rx_crc_reg   <= rx_crc_next;
            crc_reg      <= crc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg   <= kind_next;
            pbyte_reg  <= pbyte_next;
            status_reg <= status_next;
            id_reg     <= id_next;
            pcnt_reg   <= pcnt_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_payload_byte  = pbyte_reg;
    assign m_frame_status  = status_reg;
    assign m_frame_id      = id_reg;
    assign m_payload_count = pcnt_reg;

    // escape can only be pending inside a frame
    a_esc_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> in_frame_reg)
        else $error("escape pending outside a frame");

    // record count stays below the limit
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        EXT_W'(rec_cnt_reg) < MAX_EXT)
        else $error("record count reached limit");

    // a held result is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !take)
        else $error("byte taken while result stalled");

    // status results carry a zero data byte, payload results an ok status
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (kind_reg == KIND_STATUS ? pbyte_reg == 8'h00
                                                 : status_reg == ST_OK))
        else $error("result fields inconsistent with kind");

    // a payload result always comes from a frame that stays open
    a_payload_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && kind_next == KIND_PAYLOAD) |=> in_frame_reg)
        else $error("payload emitted while closing a frame");

endmodule

`default_nettype wire

[verif/escaped_frame_decoder_crc8_test.sv]
// self-checking testbench for escaped_frame_decoder_crc8: builds escaped frames, predicts
// every payload byte and end-of-frame status, compares on the m_ channel
// depends on efd_pkg and escaped_frame_decoder_crc8
module escaped_frame_decoder_crc8_test;
    import efd_pkg::*;

    localparam int unsigned RECORD_LIMIT = MAX_RECORD_DEFAULT;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          TAIL_CYCLES  = 16;
    localparam int          PHASE_BYTES  = 425;
    localparam int          PRINT_LIMIT  = 100;

    // shapes of generated frames, good ones and the ways they get broken
    typedef enum int {
        FR_GOOD,
        FR_LEN_OFF,
        FR_CRC_OFF,
        FR_CUT,
        FR_JUNK,
        FR_ESC_TAIL
    } frame_shape_t;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        result_kind_t  kind;
        logic [7:0]    data;
        frame_status_t status;
        logic [7:0]    id;
        logic [7:0]    count;
    } decoded_result_t;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_result_kind;
    logic [7:0] m_payload_byte;
    logic [2:0] m_frame_status;
    logic [7:0] m_frame_id;
    logic [7:0] m_payload_count;

    // line bytes still to be sent, and decoded results still to come out
    logic [7:0]      line_bytes[$];
    decoded_result_t decoded_results[$];

    int sent_count     = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // decoder state as seen from the line
    bit         rx_in_frame = 1'b0;
    bit         rx_escaped  = 1'b0;
    logic [8:0] rec_len     = 9'd0;
    logic [7:0] hdr_id      = 8'h00;
    logic [7:0] hdr_len     = 8'h00;
    logic [7:0] hdr_crc     = 8'h00;
    logic [7:0] run_crc     = 8'h00;

    escaped_frame_decoder_crc8 #(
        .MAX_RECORD(RECORD_LIMIT)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_status (m_frame_status),
        .m_frame_id     (m_frame_id),
        .m_payload_count(m_payload_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        // keep the log short when the design is badly off
        if (fail_count <= PRINT_LIMIT) begin
            $display("cycle %0d: %s", cycle_count, what);
        end
    endtask

    // crc-8, poly 0x07, msb first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        repeat (8) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // payload bytes stored so far, saturating at 255
    function automatic logic [7:0] payload_seen();
        int n;
        n = (rec_len > 4) ? int'(rec_len) - 4 : 0;
        return (n > 255) ? 8'hff : 8'(n);
    endfunction

    function automatic void open_record();
        rx_in_frame = 1'b1;
        rx_escaped  = 1'b0;
        rec_len     = 9'd1;
        hdr_id      = 8'h00;
        hdr_len     = 8'h00;
        hdr_crc     = 8'h00;
        run_crc     = 8'h00;
    endfunction

    // advance the decoder by one line byte and queue what it emits
    function automatic void decode_line_byte(input logic [7:0] b);
        decoded_result_t r;
        int              raw;
        if (!rx_in_frame) begin
            // hunting for a head, escapes mean nothing here
            if (b == HEAD_BYTE) begin
                open_record();
            end
            return;
        end
        r.kind   = KIND_STATUS;
        r.data   = 8'h00;
        r.status = ST_OK;
        r.id     = hdr_id;
        r.count  = payload_seen();
        if (rx_escaped) begin
            // escaped byte is plain data, even a head or a tail
            rx_escaped = 1'b0;
        end else if (b == ESC_BYTE) begin
            rx_escaped = 1'b1;
            return;
        end else if (b == HEAD_BYTE) begin
            // the old frame dies, the head opens a fresh one
            r.status = ST_ABORTED;
            decoded_results.push_back(r);
            open_record();
            return;
        end else if (b == TAIL_BYTE) begin
            raw = (rec_len > 4) ? int'(rec_len) - 4 : 0;
            if (rec_len + 1 <= OVERHEAD) begin
                r.status = ST_SHORT;
            end else if (raw != int'(hdr_len)) begin
                r.status = ST_LEN_BAD;
            end else if (run_crc != hdr_crc) begin
                r.status = ST_CRC_BAD;
            end
            decoded_results.push_back(r);
            rx_in_frame = 1'b0;
            rx_escaped  = 1'b0;
            return;
        end
        // data byte for the record; a full record drops it and ends the frame
        if (rec_len + 1 >= RECORD_LIMIT) begin
            r.status = ST_OVERFLOW;
            decoded_results.push_back(r);
            rx_in_frame = 1'b0;
            rx_escaped  = 1'b0;
            return;
        end
        case (rec_len)
            9'd1: begin
                hdr_id  = b;
                run_crc = b;
            end
            9'd2: hdr_len = b;
            9'd3: hdr_crc = b;
            default: run_crc = crc8_step(run_crc, b);
        endcase
        rec_len = rec_len + 9'd1;
        if (rec_len > 4) begin
            r.kind   = KIND_PAYLOAD;
            r.data   = b;
            r.status = ST_OK;
            r.id     = hdr_id;
            r.count  = payload_seen();
            decoded_results.push_back(r);
        end
    endfunction

    // stimulus helpers
    function automatic void send_line(input logic [7:0] b);
        line_bytes.push_back(b);
        sent_count++;
    endfunction

    function automatic void send_escaped(input logic [7:0] b);
        if (b == HEAD_BYTE || b == TAIL_BYTE || b == ESC_BYTE) begin
            send_line(ESC_BYTE);
        end
        send_line(b);
    endfunction

    // random byte, leaning on the three framing codes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return HEAD_BYTE;
            1: return TAIL_BYTE;
            2: return ESC_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // head, escaped id/length/crc/payload, tail, bent according to shape
    function automatic void add_frame(input logic [7:0] id, input byte_q_t payload,
                                      input frame_shape_t shape);
        logic [7:0] body[$];
        logic [7:0] crc;
        logic [7:0] len;
        int         stop;
        int         junk_at;
        int         k;
        crc = id;
        foreach (payload[i]) begin
            crc = crc8_step(crc, payload[i]);
        end
        len = 8'(payload.size());
        if (shape == FR_LEN_OFF) begin
            len = len + 8'($urandom_range(1, 255));
        end
        if (shape == FR_CRC_OFF) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        body = payload;
        body.push_front(crc);
        body.push_front(len);
        body.push_front(id);
        stop    = (shape == FR_CUT) ? int'($urandom_range(0, body.size())) : body.size();
        junk_at = (shape == FR_JUNK) ? int'($urandom_range(0, body.size() - 1)) : -1;
        send_line(HEAD_BYTE);
        for (k = 0; k < stop; k++) begin
            // a raw unescaped byte dropped into the middle of the frame
            if (k == junk_at) begin
                send_line(pick_byte());
            end
            send_escaped(body[k]);
        end
        if (shape == FR_CUT) begin
            return;
        end
        // an escape right before the tail turns the tail into data
        if (shape == FR_ESC_TAIL) begin
            send_line(ESC_BYTE);
        end
        send_line(TAIL_BYTE);
    endfunction

    // sender: a byte is predicted the moment its transfer happens
    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_line_byte(s_rx_byte);
            end
            // free to present the next byte unless the current one is still waiting
            if (!s_valid || s_ready) begin
                if (line_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= line_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check every result transfer against the oldest prediction
    always @(posedge aclk) begin : monitor
        decoded_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_results.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d with nothing pending",
                                              m_result_kind));
                end else begin
                    want = decoded_results.pop_front();
                    if (m_result_kind !== want.kind) begin
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  m_result_kind, want.kind));
                    end
                    if (m_payload_byte !== want.data) begin
                        report_mismatch($sformatf("payload byte %h, want %h",
                                                  m_payload_byte, want.data));
                    end
                    if (m_frame_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_frame_status, want.status));
                    end
                    if (m_frame_id !== want.id) begin
                        report_mismatch($sformatf("frame id %h, want %h",
                                                  m_frame_id, want.id));
                    end
                    if (m_payload_count !== want.count) begin
                        report_mismatch($sformatf("payload count %0d, want %0d",
                                                  m_payload_count, want.count));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int           idle_by_phase[4]  = '{0, 76, 0, 6};
        int           stall_by_phase[4] = '{0, 0, 76, 6};
        byte_q_t      payload;
        frame_shape_t shape;
        int           phase;
        int           pick;
        int           n;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < 4; phase++) begin
            @(negedge aclk);
            src_idle_pct   = idle_by_phase[phase];
            sink_stall_pct = stall_by_phase[phase];
            sent_count     = 0;

            if (phase == 0) begin
                // escape outside a frame is ignored, the head still opens
                send_line(ESC_BYTE);
                // all three codes escaped in the payload, extreme id and data
                payload = '{};
                payload.push_back(ESC_BYTE);
                payload.push_back(HEAD_BYTE);
                payload.push_back(TAIL_BYTE);
                payload.push_back(8'hff);
                add_frame(8'hff, payload, FR_GOOD);
                // head then tail: too short, no id yet
                send_line(HEAD_BYTE);
                send_line(TAIL_BYTE);
                // frame cut off by a new head, which then carries a bad length
                send_line(HEAD_BYTE);
                send_line(8'h07);
                payload = '{};
                payload.push_back(8'h00);
                add_frame(8'h00, payload, FR_LEN_OFF);
                payload = '{};
                payload.push_back(8'h55);
                add_frame(8'h01, payload, FR_CRC_OFF);
                // longest frame that still fits the record
                payload = '{};
                repeat (RECORD_LIMIT - 5) payload.push_back(pick_byte());
                add_frame(pick_byte(), payload, FR_GOOD);
            end
            if (phase == 3) begin
                // one frame too long for the record
                payload = '{};
                n = $urandom_range(RECORD_LIMIT - 4, RECORD_LIMIT - 2);
                repeat (n) payload.push_back(pick_byte());
                add_frame(pick_byte(), payload, FR_GOOD);
            end

            // mostly well-formed short frames, some broken, some line noise
            while (sent_count < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    repeat ($urandom_range(1, 4)) line_bytes.push_back(8'($urandom_range(255)));
                end else begin
                    if (pick < 60) begin
                        shape = FR_GOOD;
                    end else if (pick < 70) begin
                        shape = FR_LEN_OFF;
                    end else if (pick < 80) begin
                        shape = FR_CRC_OFF;
                    end else if (pick < 88) begin
                        shape = FR_CUT;
                    end else if (pick < 95) begin
                        shape = FR_JUNK;
                    end else begin
                        shape = FR_ESC_TAIL;
                    end
                    payload = '{};
                    repeat ($urandom_range(0, 12)) payload.push_back(pick_byte());
                    add_frame(pick_byte(), payload, shape);
                end
            end

            // hold the sender until every pending result has been drained
            do begin
                @(negedge aclk);
            end while (line_bytes.size() != 0 || s_valid || decoded_results.size() != 0);
        end

        // let any stray result show up
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (decoded_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never came out", decoded_results.size()));
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/efd_pkg.sv
rtl/escaped_frame_decoder_crc8.sv
verif/escaped_frame_decoder_crc8_test.sv
